// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is high.
`define MRCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define MRCC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mrcc_pkg.sv =====
`default_nettype none
package mrcc_pkg;

   // Item kinds on the request tuser field
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Register indexes on the csr port
   localparam logic [0:0] REG_WINDOW_TICKS = 1'b0;
   localparam logic [0:0] REG_CHECK_ENABLE = 1'b1;

   localparam logic [15:0] WINDOW_TICKS_RESET = 16'd300;
   localparam logic        CHECK_ENABLE_RESET = 1'b1;

   localparam logic [7:0]  MAX_REPLY_BYTES = 8'd255;
   localparam logic [16:0] TICK_MAX        = 17'h1FFFF;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;

   typedef struct packed {
      logic [7:0] reply_length;
      logic       crc_good;
      logic       overflowed;
   } result_type;

endpackage
`default_nettype wire

// ===== src/mrcc_crc_fold.sv =====
`default_nettype none
module mrcc_crc_fold
   import mrcc_pkg::*;
(
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data_byte,
   output logic      [15:0] crc_next
);

   logic [15:0] acc;

   // Fold one byte, least significant bit first
   always_comb begin
      acc = crc_cur ^ {8'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule
`default_nettype wire

// ===== src/mrcc_frame.sv =====
`default_nettype none
module mrcc_frame
   import mrcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic [1:0]  op,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [15:0] window_ticks,
   input  wire logic        check_enable,
   output logic             fire,
   output result_type       result
);

   logic        window_open_ff, window_open_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held_ff [2];
   logic [7:0]  held_in [2];
   logic        overflow_ff, overflow_in;
   logic [15:0] crc_folded;
   logic [16:0] elapsed_inc;
   logic        good;

   mrcc_crc_fold u_fold (
      .crc_cur   (crc_ff),
      .data_byte (held_ff[0]),
      .crc_next  (crc_folded)
   );

   assign elapsed_inc = (elapsed_ff < TICK_MAX) ? elapsed_ff + 17'd1 : elapsed_ff;
   assign fire = window_open_ff && (op == OP_TICK) && (elapsed_inc > {1'b0, window_ticks});

   assign good = (count_ff >= 8'd2) && (held_ff[0] == crc_ff[7:0])
                 && (held_ff[1] == crc_ff[15:8]);

   always_comb begin
      result.crc_good     = check_enable ? good : 1'b1;
      result.reply_length = (check_enable && !good) ? 8'd0 : count_ff;
      result.overflowed   = overflow_ff;
   end

   always_comb begin
      window_open_in = window_open_ff;
      elapsed_in     = elapsed_ff;
      count_in       = count_ff;
      crc_in         = crc_ff;
      held_in[0]     = held_ff[0];
      held_in[1]     = held_ff[1];
      overflow_in    = overflow_ff;
      case (op)
         OP_START: begin
            window_open_in = 1'b1;
            elapsed_in     = 17'd0;
            count_in       = 8'd0;
            crc_in         = CRC_INIT;
            held_in[0]     = 8'd0;
            held_in[1]     = 8'd0;
            overflow_in    = 1'b0;
         end
         OP_BYTE: begin
            if (window_open_ff) begin
               if (count_ff >= MAX_REPLY_BYTES) begin
                  overflow_in = 1'b1;
               end else begin
                  // only the byte leaving the delay enters the CRC
                  if (count_ff >= 8'd2) begin
                     crc_in = crc_folded;
                  end
                  held_in[0] = held_ff[1];
                  held_in[1] = rx_byte;
                  count_in   = count_ff + 8'd1;
               end
            end
         end
         OP_TICK: begin
            if (window_open_ff) begin
               elapsed_in = elapsed_inc;
               if (fire) begin
                  window_open_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_open_ff <= 1'b0;
         elapsed_ff     <= 17'd0;
         count_ff       <= 8'd0;
         crc_ff         <= CRC_INIT;
         held_ff[0]     <= 8'd0;
         held_ff[1]     <= 8'd0;
         overflow_ff    <= 1'b0;
      end else if (advance) begin
         window_open_ff <= window_open_in;
         elapsed_ff     <= elapsed_in;
         count_ff       <= count_in;
         crc_ff         <= crc_in;
         held_ff[0]     <= held_in[0];
         held_ff[1]     <= held_in[1];
         overflow_ff    <= overflow_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/mrcc_rsp_reg.sv =====
`default_nettype none
module mrcc_rsp_reg
   import mrcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type result,
   input  wire logic       rsp_tready,
   output logic            rsp_tvalid,
   output logic [7:0]      rsp_tdata,
   output logic [1:0]      rsp_tuser
);

   logic       valid_ff;
   result_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // hold the payload until the next item is loaded
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.reply_length;
   assign rsp_tuser  = {data_ff.overflowed, data_ff.crc_good};

endmodule
`default_nettype wire

// ===== src/modbus_rtu_reply_crc_checker.sv =====
`default_nettype none
// Modbus RTU reply checker. A start item opens a reply window; received-byte
// items are counted and run through a two-byte delay into a CRC-16/MODBUS,
// and tick items advance the window timer. On the tick on which the elapsed
// count passes window_ticks one result is given: the byte count (zero on a
// failed check when checking is on), the CRC verdict and an overflow flag.
// One item is accepted every clock cycle unless a closing tick is stalled.
// Each accepted item is held in the input register, where the CRC byte
// update and the frame decision run on it; the result of a tick that closes
// a window is registered on rsp_. The input register keeps taking items
// while a result waits on rsp_; only a tick that closes a window waits there
// until the previous result has been taken.
module modbus_rtu_reply_crc_checker
   import mrcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [7:0] reply_length
   output logic      [1:0]  rsp_tuser,   // [0] crc_good, [1] overflowed
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic        item_valid_ff;
   logic [1:0]  item_op_ff;
   logic [7:0]  item_byte_ff;
   logic [15:0] window_ticks_ff;
   logic        check_enable_ff;
   logic        fire;
   logic        advance;
   result_type  result;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ticks_ff <= WINDOW_TICKS_RESET;
         check_enable_ff <= CHECK_ENABLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_WINDOW_TICKS: window_ticks_ff <= csr_wdata;
            REG_CHECK_ENABLE: check_enable_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // a closing tick stalls only while the previous result is untaken
   assign advance    = item_valid_ff && (!fire || !rsp_tvalid || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_op_ff   <= req_tuser;
         item_byte_ff <= req_tdata;
      end
   end

   mrcc_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .op           (item_op_ff),
      .rx_byte      (item_byte_ff),
      .window_ticks (window_ticks_ff),
      .check_enable (check_enable_ff),
      .fire         (fire),
      .result       (result)
   );

   mrcc_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && fire),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== src/mrcc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module mrcc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser
);

   `MRCC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result item changed while stalled")
   `MRCC_ASSERT(a_fail_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0, "failed check with non-zero length")
   `MRCC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result item valid after reset")

endmodule

bind modbus_rtu_reply_crc_checker mrcc_checker u_mrcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== verif/modbus_rtu_reply_crc_checker_tb.sv =====
`timescale 1ns / 100ps
module modbus_rtu_reply_crc_checker_tb;
   import mrcc_pkg::*;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         SETTLE_CYCLES  = 6;
   localparam int         STALL_LIMIT    = 5000;
   localparam int         HOLDOFF_CYCLES = 400;
   localparam int         RANDOM_ITEMS   = 200;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] rx_byte
   logic [1:0]  req_tuser  = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] reply_length
   logic [1:0]  rsp_tuser;         // [0] crc_good, [1] overflowed
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   // Shadow of the checker's frame state and registers
   logic        frame_open;
   logic [16:0] ticks_seen;
   logic [7:0]  rx_count;
   logic [15:0] crc_acc;
   logic [7:0]  held_lo;
   logic [7:0]  held_hi;
   logic        ovf_flag;
   logic [15:0] cfg_window;
   logic        cfg_check;

   result_type  replies_due[$];
   int          live_items   = 0;
   int          mismatches   = 0;
   bit          src_calm     = 1'b0;
   bit          sink_calm    = 1'b0;
   int          sink_holdoff = 0;

   modbus_rtu_reply_crc_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic void reset_frame();
      ticks_seen = '0;
      rx_count   = '0;
      crc_acc    = CRC_INIT;
      held_lo    = '0;
      held_hi    = '0;
      ovf_flag   = 1'b0;
   endfunction

   // Advance the shadow frame by one accepted item; queue the verdict when a window closes
   task automatic advance_frame(input logic [1:0] op, input logic [7:0] data);
      result_type r;
      if (op == OP_START) begin
         reset_frame();
         frame_open = 1'b1;
         live_items++;
         return;
      end
      if (!frame_open || op == OP_UNUSED)
         return;
      live_items++;
      if (op == OP_BYTE) begin
         if (rx_count == MAX_REPLY_BYTES) begin
            ovf_flag = 1'b1;
            return;
         end
         // only the byte leaving the two-byte delay enters the CRC
         if (rx_count >= 2)
            crc_acc = crc16_fold(crc_acc, held_lo);
         held_lo  = held_hi;
         held_hi  = data;
         rx_count = rx_count + 8'd1;
         return;
      end
      if (ticks_seen != TICK_MAX)
         ticks_seen = ticks_seen + 17'd1;
      if (ticks_seen <= {1'b0, cfg_window})
         return;
      frame_open = 1'b0;
      if (cfg_check) begin
         r.crc_good     = rx_count >= 2 && held_lo == crc_acc[7:0] && held_hi == crc_acc[15:8];
         r.reply_length = r.crc_good ? rx_count : 8'd0;
      end else begin
         r.crc_good     = 1'b1;
         r.reply_length = rx_count;
      end
      r.overflowed = ovf_flag;
      replies_due.push_back(r);
   endtask

   task automatic send_item(input logic [1:0] op, input logic [7:0] data);
      while (!src_calm && $urandom_range(99) < 16) begin
         @(negedge clock) req_tvalid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      advance_frame(op, data);
   endtask

   task automatic close_window();
      while (frame_open)
         send_item(OP_TICK, 8'($urandom_range(255)));
   endtask

   // Hold the sender until every verdict is in and the pipeline has gone quiet
   task automatic drain_results();
      @(negedge clock) req_tvalid <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index == REG_WINDOW_TICKS)
         cfg_window = value;
      else
         cfg_check = value[0];
   endtask

   task automatic reconfigure(input logic [15:0] span, input logic check);
      close_window();
      drain_results();
      write_reg(REG_WINDOW_TICKS, span);
      write_reg(REG_CHECK_ENABLE, {15'd0, check});
   endtask

   // Start a window, send a payload and its CRC trailer; optionally spoil one CRC bit
   task automatic send_reply(input int payload_len, input bit spoil);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = CRC_INIT;
      send_item(OP_START, 8'($urandom_range(255)));
      for (int i = 0; i < payload_len; i++) begin
         b   = 8'($urandom_range(255));
         crc = crc16_fold(crc, b);
         send_item(OP_BYTE, b);
         if ($urandom_range(99) < 8)
            send_item(OP_TICK, 8'($urandom_range(255)));
      end
      if (spoil)
         crc = crc ^ (16'd1 << $urandom_range(15));
      send_item(OP_BYTE, crc[7:0]);
      send_item(OP_BYTE, crc[15:8]);
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            flag_mismatch("unexpected result, reply_length", int'(rsp_tdata), 0);
         end else begin
            want = replies_due.pop_front();
            if (rsp_tdata != want.reply_length)
               flag_mismatch("reply_length", int'(rsp_tdata), int'(want.reply_length));
            if (rsp_tuser[0] != want.crc_good)
               flag_mismatch("crc_good", int'(rsp_tuser[0]), int'(want.crc_good));
            if (rsp_tuser[1] != want.overflowed)
               flag_mismatch("overflowed", int'(rsp_tuser[1]), int'(want.overflowed));
         end
      end
   end

   // Receiver: random stalls, calm stretches and a counted hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (sink_holdoff > 0) begin
            rsp_tready <= 1'b0;
            sink_holdoff--;
         end else if (sink_calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 16);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("modbus_rtu_reply_crc_checker test failed");
      $finish;
   end

   task automatic test_reset_values();
      // idle items before any window are ignored
      send_item(OP_BYTE, 8'hA5);
      send_item(OP_TICK, 8'h00);
      send_item(OP_UNUSED, 8'hFF);
      send_reply(4, 1'b0);
      close_window();
      drain_results();
   endtask

   task automatic test_frame_cases();
      reconfigure(16'd2, 1'b1);
      // empty and one-byte frames fail the check
      send_item(OP_START, 8'h00);
      close_window();
      send_item(OP_START, 8'hFF);
      send_item(OP_BYTE, 8'hFF);
      close_window();
      // bare trailer: CRC of nothing
      send_reply(0, 1'b0);
      close_window();
      send_reply(3, 1'b1);
      close_window();
      // restart mid-window drops the partial frame
      send_item(OP_START, 8'h5A);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_reply(2, 1'b0);
      send_item(OP_UNUSED, 8'h3C);
      close_window();
      send_item(OP_BYTE, 8'h11);
      send_item(OP_TICK, 8'h22);
      reconfigure(16'd0, 1'b0);
      send_item(OP_START, 8'h00);
      send_item(OP_BYTE, 8'h80);
      send_item(OP_TICK, 8'h01);
      reconfigure(16'd1, 1'b0);
      send_reply(3, 1'b1);
      close_window();
      send_item(OP_START, 8'h00);
      close_window();
      drain_results();
   endtask

   task automatic test_count_full();
      reconfigure(16'd40, 1'b1);
      send_reply(253, 1'b0);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, 8'h00);
      close_window();
      reconfigure(16'd40, 1'b0);
      send_reply(253, 1'b1);
      send_item(OP_BYTE, 8'h77);
      close_window();
      drain_results();
   endtask

   task automatic test_window_extremes();
      reconfigure(16'hFFFF, 1'b1);
      src_calm = 1'b1;
      send_reply(6, 1'b0);
      repeat (20)
         send_item(OP_TICK, 8'h00);
      src_calm = 1'b0;
      // shrink the window under the open frame
      drain_results();
      write_reg(REG_WINDOW_TICKS, 16'd30);
      close_window();
      reconfigure(16'd0, 1'b1);
      send_item(OP_START, 8'h00);
      send_item(OP_TICK, 8'h00);
      drain_results();
   endtask

   task automatic test_backpressure();
      reconfigure(16'd1, 1'b1);
      sink_holdoff = HOLDOFF_CYCLES;
      // keep offering short frames so closing ticks back up behind the held result
      repeat (20) begin
         send_reply($urandom_range(4), 1'($urandom_range(1)));
         close_window();
      end
      drain_results();
   endtask

   task automatic test_random_traffic();
      int          goal;
      int          phase;
      int          pick;
      int          len;
      logic [15:0] span;
      goal  = live_items + RANDOM_ITEMS;
      phase = 0;
      while (live_items < goal) begin
         pick = $urandom_range(9);
         span = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : 16'($urandom_range(40, 2));
         reconfigure(span, 1'($urandom_range(1)));
         src_calm  = (phase == 0);
         sink_calm = (phase == 0);
         repeat ($urandom_range(10, 4)) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               len = ($urandom_range(99) < 5) ? $urandom_range(256, 200) : $urandom_range(10);
               send_reply(len, $urandom_range(99) < 20);
               if ($urandom_range(99) < 80)
                  close_window();
            end else if (pick < 85) begin
               send_item(OP_START, 8'($urandom_range(255)));
               repeat ($urandom_range(1))
                  send_item(OP_BYTE, 8'($urandom_range(255)));
            end else begin
               repeat ($urandom_range(20, 1))
                  send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
         end
         phase++;
      end
      src_calm  = 1'b0;
      sink_calm = 1'b0;
      close_window();
      drain_results();
   endtask

   initial begin
      cfg_window = WINDOW_TICKS_RESET;
      cfg_check  = CHECK_ENABLE_RESET;
      frame_open = 1'b0;
      reset_frame();
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_reset_values();
      test_frame_cases();
      test_count_full();
      test_window_extremes();
      test_backpressure();
      test_random_traffic();

      drain_results();
      if (mismatches == 0)
         $display("modbus_rtu_reply_crc_checker test passed");
      else
         $display("modbus_rtu_reply_crc_checker test failed");
      $finish;
   end

endmodule
